// ===== hw/rtl/bbe_pkg.sv =====
// Shared types, constants and the divider reciprocal table for the 3x3 box blur.
package bbe_pkg;

	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int SUM_W      = 12;
	localparam int CNT_W      = 4;
	localparam int DIV_X_W    = 13;
	localparam int RECIP_W    = 18;
	localparam int RECIP_SHIFT = 18;
	localparam int PROD_W     = DIV_X_W + RECIP_W;

	localparam int FW_W       = 11;
	localparam int FH_W       = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [FW_W-1:0] FW_RESET = 11'd640;
	localparam logic [FH_W-1:0] FH_RESET = 16'd480;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} bbe_op_t;

	// Per-item decisions taken when the item enters the front.
	typedef struct packed {
		logic emit;
		logic fend;
		logic col_lo;
		logic col_hi;
		logic row_lo;
		logic row_hi;
	} bbe_ctl_t;

	// Masked window sums handed from front to back.
	typedef struct packed {
		logic [SUM_W-1:0] sum_r;
		logic [SUM_W-1:0] sum_g;
		logic [SUM_W-1:0] sum_b;
		logic [CNT_W-1:0] cnt;
		logic             fend;
	} bbe_job_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            fend;
	} bbe_res_t;

	localparam int JOB_W = $bits(bbe_job_t);
	localparam int RES_W = $bits(bbe_res_t);

	// ceil(2^18 / (2*cnt)); exact floor division for every dividend below 2^13.
	function automatic logic [RECIP_W-1:0] bbe_recip(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] r;
		unique case (cnt)
			4'd1:    r = 18'd131072;
			4'd2:    r = 18'd65536;
			4'd3:    r = 18'd43691;
			4'd4:    r = 18'd32768;
			4'd6:    r = 18'd21846;
			4'd9:    r = 18'd14564;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/bbe_fifo.sv =====
// Small register queue used between front and back and on the result side.
module bbe_fifo import bbe_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign rdata = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

`ifndef SYNTH
	a_fill_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty)
		else $error("queue still empty after a write");
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push && count_q == CW'(1)) |=> empty)
		else $error("queue not empty after its last entry left");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");
`endif

endmodule

// ===== hw/rtl/bbe_front.sv =====
// Front: position counters, line stores, 3x3 window and masked window sums.
module bbe_front import bbe_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [FW_W-1:0] frame_width,
	input  logic [FH_W-1:0] frame_height,
	input  logic            in_push,
	output logic            in_ready,
	input  logic            opcode,
	input  logic [CH_W-1:0] red,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] blue,
	input  logic            job_full,
	output logic            job_push,
	output bbe_job_t        job
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam logic [CW-1:0] COL_MAX = CW'(MAX_WIDTH);

	logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

	logic [CW-1:0]   in_col_q, out_col_q;
	logic [FH_W-1:0] in_row_q, out_row_q;
	logic [CW-1:0]   in_col_d, out_col_d;
	logic [FH_W-1:0] in_row_d, out_row_d;

	logic [CW-1:0]   eff_w;
	logic [FH_W-1:0] eff_h;
	logic [CW-1:0]   in_col_inc, out_col_inc;
	logic [FH_W:0]   out_row_inc;
	logic            in_wrap, out_col_wrap, out_row_wrap;
	bbe_ctl_t        ctl_c;
	logic            accept;
	logic [AW-1:0]   adr_in;

	logic             valid_s1;
	bbe_ctl_t         ctl_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [AW-1:0]    adr_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fwd_up_s1, fwd_mid_s1;
	logic [PIX_W-1:0] rd_up_s1, rd_mid_s1;
	logic             s1_adv;

	logic [PIX_W-1:0] up_eff, mid_eff;
	logic [2:0][PIX_W-1:0] col0_q, col1_q;
	logic [2:0][2:0][PIX_W-1:0] win;
	logic [2:0] col_ok, row_ok;

	always_comb begin
		if (frame_width == '0) begin
			eff_w = CW'(1);
		end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
			eff_w = COL_MAX;
		end else begin
			eff_w = CW'(frame_width);
		end
	end
	assign eff_h = (frame_height == '0) ? FH_W'(1) : frame_height;

	assign adr_in   = in_col_q[AW-1:0];
	assign s1_adv   = valid_s1 && (!ctl_s1.emit || !job_full);
	assign in_ready = !valid_s1 || s1_adv;
	assign accept   = in_push && in_ready;
	assign job_push = valid_s1 && ctl_s1.emit && !job_full;

	// Position bookkeeping for the item being taken now.
	always_comb begin
		in_col_inc   = in_col_q + CW'(1);
		in_wrap      = (in_col_inc >= eff_w);
		out_col_inc  = out_col_q + CW'(1);
		out_col_wrap = (out_col_inc >= eff_w);
		out_row_inc  = {1'b0, out_row_q} + (FH_W+1)'(1);
		out_row_wrap = (out_row_inc >= {1'b0, eff_h});

		ctl_c.emit   = (in_row_q >= FH_W'(2)) || (in_row_q == FH_W'(1) && in_col_q != '0);
		ctl_c.fend   = ctl_c.emit && out_col_wrap && out_row_wrap;
		ctl_c.col_lo = (out_col_q != '0);
		ctl_c.col_hi = !out_col_wrap;
		ctl_c.row_lo = (out_row_q != '0);
		ctl_c.row_hi = !out_row_wrap;

		in_col_d  = in_wrap ? '0 : in_col_inc;
		in_row_d  = (in_wrap && in_row_q != '1) ? in_row_q + FH_W'(1) : in_row_q;
		out_col_d = out_col_q;
		out_row_d = out_row_q;
		if (ctl_c.emit) begin
			if (out_col_wrap) begin
				out_col_d = '0;
				out_row_d = out_row_wrap ? '0 : out_row_inc[FH_W-1:0];
			end else begin
				out_col_d = out_col_inc;
			end
		end
		if (ctl_c.fend) begin
			in_col_d = '0;
			in_row_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			in_col_q  <= in_col_d;
			in_row_q  <= in_row_d;
			out_col_q <= out_col_d;
			out_row_q <= out_row_d;
		end
	end

	// Line store entries the item at stage 1 reads; forward when the item just
	// ahead wrote the same column (one-pixel-wide frames).
	assign up_eff  = fwd_s1 ? fwd_up_s1  : rd_up_s1;
	assign mid_eff = fwd_s1 ? fwd_mid_s1 : rd_mid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			fwd_s1   <= valid_s1 && (adr_s1 == adr_in);
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1     <= ctl_c;
			pix_s1     <= (opcode == OP_DRAIN) ? '0 : {red, green, blue};
			adr_s1     <= adr_in;
			fwd_up_s1  <= mid_eff;
			fwd_mid_s1 <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			upper_mem[adr_s1]  <= mid_eff;
			middle_mem[adr_s1] <= pix_s1;
		end
		if (accept) begin
			rd_up_s1  <= upper_mem[adr_in];
			rd_mid_s1 <= middle_mem[adr_in];
		end
	end

	// Window: two held columns plus the column of the item at stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col0_q <= '0;
			col1_q <= '0;
		end else if (s1_adv) begin
			col0_q <= col1_q;
			col1_q <= {pix_s1, mid_eff, up_eff};
		end
	end

	assign win    = {{pix_s1, mid_eff, up_eff}, col1_q, col0_q};
	assign col_ok = {ctl_s1.col_hi, 1'b1, ctl_s1.col_lo};
	assign row_ok = {ctl_s1.row_hi, 1'b1, ctl_s1.row_lo};

	always_comb begin
		logic [SUM_W-1:0] sr, sg, sb;
		logic [CNT_W-1:0] n;
		sr = '0;
		sg = '0;
		sb = '0;
		n  = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (col_ok[i] && row_ok[j]) begin
					sr = sr + SUM_W'(win[i][j][2*CH_W +: CH_W]);
					sg = sg + SUM_W'(win[i][j][CH_W +: CH_W]);
					sb = sb + SUM_W'(win[i][j][0 +: CH_W]);
					n  = n + CNT_W'(1);
				end
			end
		end
		job.sum_r = sr;
		job.sum_g = sg;
		job.sum_b = sb;
		job.cnt   = n;
		job.fend  = ctl_s1.fend;
	end

`ifndef SYNTH
	a_cnt_legal: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> (job.cnt == CNT_W'(1) || job.cnt == CNT_W'(2) || job.cnt == CNT_W'(3) ||
			job.cnt == CNT_W'(4) || job.cnt == CNT_W'(6) || job.cnt == CNT_W'(9)))
		else $error("window count outside the legal set");
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ctl_c.fend) |=>
		(in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0))
		else $error("counters not cleared after frame end");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ctl_s1.emit && job_full) |-> !in_ready)
		else $error("front takes a request while its stage is blocked");
`endif

endmodule

// ===== hw/rtl/bbe_back.sv =====
// Back: rounded mean per channel by reciprocal multiply, two stages.
module bbe_back import bbe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     job_valid,
	input  bbe_job_t job,
	output logic     job_pop,
	input  logic     res_full,
	output logic     res_push,
	output bbe_res_t res
);

	logic               valid_s1, valid_s2;
	logic [DIV_X_W-1:0] x_r_s1, x_g_s1, x_b_s1;
	logic [RECIP_W-1:0] recip_s1;
	logic               fend_s1;
	bbe_res_t           res_s2;
	logic [PROD_W-1:0]  prod_r, prod_g, prod_b;
	logic               s1_ready, s2_ready;

	assign s2_ready = !valid_s2 || !res_full;
	assign s1_ready = !valid_s1 || s2_ready;
	assign job_pop  = job_valid && s1_ready;
	assign res_push = valid_s2 && !res_full;
	assign res      = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= job_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Dividend 2*sum+cnt, divisor 2*cnt folded into the reciprocal.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			x_r_s1   <= (DIV_X_W'(job.sum_r) << 1) + DIV_X_W'(job.cnt);
			x_g_s1   <= (DIV_X_W'(job.sum_g) << 1) + DIV_X_W'(job.cnt);
			x_b_s1   <= (DIV_X_W'(job.sum_b) << 1) + DIV_X_W'(job.cnt);
			recip_s1 <= bbe_recip(job.cnt);
			fend_s1  <= job.fend;
		end
	end

	assign prod_r = PROD_W'(x_r_s1) * PROD_W'(recip_s1);
	assign prod_g = PROD_W'(x_g_s1) * PROD_W'(recip_s1);
	assign prod_b = PROD_W'(x_b_s1) * PROD_W'(recip_s1);

	always_ff @(posedge clk) begin
		if (valid_s1 && s2_ready) begin
			res_s2.red   <= prod_r[RECIP_SHIFT +: CH_W];
			res_s2.green <= prod_g[RECIP_SHIFT +: CH_W];
			res_s2.blue  <= prod_b[RECIP_SHIFT +: CH_W];
			res_s2.fend  <= fend_s1;
		end
	end

endmodule

// ===== hw/rtl/box_blur_3x3_edge_aware.sv =====
// Top level of the edge-aware 3x3 box blur: config registers and block wiring.
//
// Usage: pixels enter in raster order on the input queue port (push/full);
// an item is taken at a clock edge with push high and full low. opcode selects
// a pixel or a drain request; a drain request stands for a black pixel. Each
// request takes the next raster position. Results leave on the output queue
// port (empty/pop): the oldest result is on out_* while empty is low and is
// taken at an edge with pop high. frame_end marks the last result of a frame.
// A result belongs to the request frame_width+1 positions later, so after the
// last pixel send frame_width+1 drain requests to flush the frame.
// Throughput: one request per clock; each line store takes one read and one
// write per cycle, and the front stage advances every cycle the back keeps up.
// Path: a result reaches out_* after the edge that took the request causing it,
// by way of the front/back queue, dividend, multiply and result queue registers.
// If the receiver stalls, results gather in the output queue, then the back
// and the front/back queue fill, then full rises; nothing is dropped.
// Config: wr_en writes wr_data into register wr_index (0 frame width,
// 1 frame height) at once; write only while the block is idle.
// Reset (arst_n low) clears all counters and queues and loads 640 x 480; line
// store contents need no clearing.
module box_blur_3x3_edge_aware import bbe_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  opcode,
	input  logic [CH_W-1:0]       in_red,
	input  logic [CH_W-1:0]       in_green,
	input  logic [CH_W-1:0]       in_blue,
	output logic                  empty,
	input  logic                  pop,
	output logic [CH_W-1:0]       out_red,
	output logic [CH_W-1:0]       out_green,
	output logic [CH_W-1:0]       out_blue,
	output logic                  frame_end,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	logic [FW_W-1:0] frame_width_q;
	logic [FH_W-1:0] frame_height_q;

	logic             in_ready;
	logic             job_push, job_full, job_empty, job_pop;
	bbe_job_t         job_in, job_out;
	logic [JOB_W-1:0] job_rdata;
	logic             res_push, res_full;
	bbe_res_t         res_in, res_out;
	logic [RES_W-1:0] res_rdata;
	logic             out_pop;

	// Hold the geometry registers; write takes effect on the next edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FRAME_WIDTH:  frame_width_q  <= wr_data[FW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= wr_data[FH_W-1:0];
			endcase
		end
	end

	assign full = !in_ready;

	bbe_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_width (frame_width_q),
		.frame_height(frame_height_q),
		.in_push     (push),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.red         (in_red),
		.green       (in_green),
		.blue        (in_blue),
		.job_full    (job_full),
		.job_push    (job_push),
		.job         (job_in)
	);

	// Decouple front from back so each can stall on its own.
	bbe_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(4)
	) u_job_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.wdata (job_in),
		.full  (job_full),
		.pop   (job_pop),
		.rdata (job_rdata),
		.empty (job_empty)
	);

	assign job_out = bbe_job_t'(job_rdata);

	bbe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(!job_empty),
		.job      (job_out),
		.job_pop  (job_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	// Result queue: holds finished pixels while the receiver stalls.
	assign out_pop = pop && !empty;

	bbe_fifo #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (out_pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assign res_out   = bbe_res_t'(res_rdata);
	assign out_red   = res_out.red;
	assign out_green = res_out.green;
	assign out_blue  = res_out.blue;
	assign frame_end = res_out.fend;

endmodule

// ===== tb/tb_box_blur_3x3_edge_aware.sv =====
// Self-checking testbench for the edge-aware 3x3 box blur: random frames, predicted pixels.
module tb_box_blur_3x3_edge_aware;
	import bbe_pkg::*;

	localparam int MAX_W           = 1024;
	localparam int HALF_PERIOD     = 6;
	localparam int RESET_CYCLES    = 6;
	localparam int SETTLE_CYCLES   = 8;     // margin for the pipe to go quiet
	localparam int DRAIN_CYCLES    = 16;
	localparam int RX_HOLD_CYCLES  = 400;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int WIDE_RUN        = 12;
	localparam int ROW_LIMIT       = 65535;
	localparam int MAX_REPORTS     = 10;

	// Blur predictor plus the queue of blurred pixels still owed by the block.
	class blur_scoreboard;
		logic [FW_W-1:0]  width_reg;
		logic [FH_W-1:0]  height_reg;
		logic [PIX_W-1:0] upper_row [MAX_W];
		logic [PIX_W-1:0] middle_row [MAX_W];
		logic [PIX_W-1:0] window_px [3][3];   // [column left..right][row top..bottom]
		int unsigned      in_col, in_row, out_col, out_row;
		bbe_res_t         blurred_q [$];
		int unsigned      mismatches;
		bit               frame_closed;

		function new();
			width_reg  = FW_RESET;
			height_reg = FH_RESET;
			foreach (upper_row[i]) begin
				upper_row[i]  = '0;
				middle_row[i] = '0;
			end
			foreach (window_px[i, j]) window_px[i][j] = '0;
			in_col       = 0;
			in_row       = 0;
			out_col      = 0;
			out_row      = 0;
			mismatches   = 0;
			frame_closed = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_FRAME_WIDTH) begin
				width_reg = data[FW_W-1:0];
			end else begin
				height_reg = data[FH_W-1:0];
			end
		endfunction

		// Effective frame size after clamping
		function int unsigned cols();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_W) return MAX_W;
			return 32'(width_reg);
		endfunction

		function int unsigned rows();
			return (height_reg == 0) ? 1 : 32'(height_reg);
		endfunction

		function int unsigned pending();
			return blurred_q.size();
		endfunction

		function logic [CH_W-1:0] round_mean(int unsigned sum, int unsigned cnt);
			int unsigned q;
			q = (2 * sum + cnt) / (2 * cnt);
			return q[CH_W-1:0];
		endfunction

		// Advance one raster position; queue the blurred pixel it releases, if any.
		function void note_request(bbe_op_t op, logic [CH_W-1:0] r, logic [CH_W-1:0] g,
				logic [CH_W-1:0] b);
			logic [PIX_W-1:0] pix, up, mid, v;
			int unsigned      w, h, sum_r, sum_g, sum_b, cnt;
			bit               emit;
			bit               col_ok [3];
			bit               row_ok [3];
			bbe_res_t         res;
			int               i, j;

			w   = cols();
			h   = rows();
			pix = (op == OP_PIXEL) ? {r, g, b} : '0;
			up  = '0;
			mid = '0;
			if (in_col < MAX_W) begin
				up  = upper_row[in_col];
				mid = middle_row[in_col];
				upper_row[in_col]  = mid;
				middle_row[in_col] = pix;
			end
			for (i = 0; i < 2; i++)
				for (j = 0; j < 3; j++)
					window_px[i][j] = window_px[i + 1][j];
			window_px[2][0] = up;
			window_px[2][1] = mid;
			window_px[2][2] = pix;

			emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				if (in_row < ROW_LIMIT) in_row++;
			end
			frame_closed = 1'b0;
			if (!emit) return;

			col_ok[0] = out_col > 0;
			col_ok[1] = 1'b1;
			col_ok[2] = out_col + 1 < w;
			row_ok[0] = out_row > 0;
			row_ok[1] = 1'b1;
			row_ok[2] = out_row + 1 < h;
			sum_r = 0;
			sum_g = 0;
			sum_b = 0;
			cnt   = 0;
			for (i = 0; i < 3; i++) begin
				for (j = 0; j < 3; j++) begin
					if (col_ok[i] && row_ok[j]) begin
						v = window_px[i][j];
						sum_r += 32'(v[23:16]);
						sum_g += 32'(v[15:8]);
						sum_b += 32'(v[7:0]);
						cnt++;
					end
				end
			end
			res.red   = round_mean(sum_r, cnt);
			res.green = round_mean(sum_g, cnt);
			res.blue  = round_mean(sum_b, cnt);
			res.fend  = 1'b0;

			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
				if (out_row >= h) begin
					res.fend     = 1'b1;
					out_row      = 0;
					in_col       = 0;
					in_row       = 0;
					frame_closed = 1'b1;
				end
			end
			blurred_q.push_back(res);
		endfunction

		function void report(string what, bbe_res_t want, bbe_res_t got);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s: expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
					$time, what, want.red, want.green, want.blue, want.fend,
					got.red, got.green, got.blue, got.fend);
		endfunction

		function void check_result(bbe_res_t got);
			bbe_res_t want;
			if (blurred_q.size() == 0) begin
				report("blurred pixel with none pending", '0, got);
				return;
			end
			want = blurred_q.pop_front();
			if (got.red !== want.red || got.green !== want.green ||
					got.blue !== want.blue || got.fend !== want.fend)
				report("blurred pixel mismatch", want, got);
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  push      = 1'b0;
	logic                  full;
	bbe_op_t               opcode    = OP_PIXEL;
	logic [CH_W-1:0]       in_red    = '0;
	logic [CH_W-1:0]       in_green  = '0;
	logic [CH_W-1:0]       in_blue   = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	logic [CH_W-1:0]       out_red;
	logic [CH_W-1:0]       out_green;
	logic [CH_W-1:0]       out_blue;
	logic                  frame_end;
	logic                  wr_en     = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index  = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0] wr_data   = '0;

	logic                  rx_hold_req = 1'b0;
	logic                  rx_hold     = 1'b0;
	int unsigned           send_idle_pct = 0;
	int unsigned           recv_idle_pct = 0;
	int unsigned           quiet_cycles;
	blur_scoreboard        blur_sb;

	box_blur_3x3_edge_aware #(
		.MAX_WIDTH(MAX_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.opcode   (opcode),
		.in_red   (in_red),
		.in_green (in_green),
		.in_blue  (in_blue),
		.empty    (empty),
		.pop      (pop),
		.out_red  (out_red),
		.out_green(out_green),
		.out_blue (out_blue),
		.frame_end(frame_end),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Check each popped pixel against the oldest prediction, then pick the next
	// pop: hold it low during a forced stall, else drop it at the idle rate.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			blur_sb.check_result({out_red, out_green, out_blue, frame_end});
		if (rx_hold) begin
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Long receiver stall on request, counted here so the sender keeps going
	// and the block has to fill up and raise full.
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold     <= 1'b1;
				rx_hold_req <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		end
	end

	// Abort when neither port moves a request for too long.
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Mostly uniform values, with the channel extremes pulled in often.
	function automatic logic [CH_W-1:0] pick_channel();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return CH_W'($urandom_range(255));
		endcase
	endfunction

	// Offer one request after a random gap, hold it until taken, then note it.
	task automatic send_item(input bbe_op_t op, input logic [CH_W-1:0] r,
			input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push     <= 1'b1;
		opcode   <= op;
		in_red   <= r;
		in_green <= g;
		in_blue  <= b;
		do @(posedge clk); while (!(push && !full));
		blur_sb.note_request(op, r, g, b);
	endtask

	task automatic send_random(input bbe_op_t op);
		send_item(op, pick_channel(), pick_channel(), pick_channel());
	endtask

	// Stop sending, wait out every owed pixel, then let the pipe go quiet.
	task automatic settle_block();
		push <= 1'b0;
		while (blur_sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write width and/or height on consecutive edges; call only when settled.
	task automatic program_frame(input bit set_w, input logic [CFG_DATA_W-1:0] w,
			input bit set_h, input logic [CFG_DATA_W-1:0] h);
		if (set_w) begin
			wr_en    <= 1'b1;
			wr_index <= REG_FRAME_WIDTH;
			wr_data  <= w;
			@(posedge clk);
			blur_sb.write_reg(REG_FRAME_WIDTH, w);
		end
		if (set_h) begin
			wr_en    <= 1'b1;
			wr_index <= REG_FRAME_HEIGHT;
			wr_data  <= h;
			@(posedge clk);
			blur_sb.write_reg(REG_FRAME_HEIGHT, h);
		end
		wr_en <= 1'b0;
	endtask

	// Feed the current frame to its end. Inside the picture send pixels, with
	// hole_pct of them turned into black drain requests; past the picture send
	// drain requests, with stray_pct of them turned into stray pixels.
	task automatic run_frame(input int unsigned hole_pct, input int unsigned stray_pct,
			output int unsigned sent);
		bbe_op_t op;
		sent = 0;
		do begin
			if (blur_sb.in_row < blur_sb.rows()) begin
				if ($urandom_range(99) < hole_pct) op = OP_DRAIN;
				else op = OP_PIXEL;
			end else begin
				if ($urandom_range(99) < stray_pct) op = OP_PIXEL;
				else op = OP_DRAIN;
			end
			send_random(op);
			sent++;
		end while (!blur_sb.frame_closed);
	endtask

	// Small random geometry, now and then a clamped zero, a quarter of frames broken.
	task automatic random_frame(output int unsigned sent);
		logic [CFG_DATA_W-1:0] w, h;
		int unsigned           pick;
		pick = $urandom_range(99);
		if (pick < 5) w = '0;
		else if (pick < 15) w = CFG_DATA_W'($urandom_range(24, 9));
		else w = CFG_DATA_W'($urandom_range(8, 1));
		pick = $urandom_range(99);
		if (pick < 5) h = '0;
		else if (pick < 10) h = CFG_DATA_W'($urandom_range(12, 7));
		else h = CFG_DATA_W'($urandom_range(6, 1));
		settle_block();
		program_frame(1'b1, w, 1'b1, h);
		if ($urandom_range(3) == 0) run_frame(10, 50, sent);
		else run_frame(0, 0, sent);
	endtask

	task automatic random_frames();
		int unsigned sent, count;
		count = 0;
		while (count < ITEMS_PER_PHASE) begin
			random_frame(sent);
			count += sent;
		end
	endtask

	task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
		send_idle_pct = tx_pct;
		recv_idle_pct <= rx_pct;
	endtask

	initial begin
		int unsigned sent;

		blur_sb = new();
		set_idling(29, 59);
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Start at the reset geometry (640 x 480): channel extremes, primaries,
		// alternating bit patterns, and a drain request inside the picture.
		send_item(OP_PIXEL, 8'd0, 8'd0, 8'd0);
		send_item(OP_PIXEL, 8'd255, 8'd255, 8'd255);
		send_item(OP_PIXEL, 8'd255, 8'd0, 8'd0);
		send_item(OP_PIXEL, 8'd0, 8'd255, 8'd0);
		send_item(OP_PIXEL, 8'd0, 8'd0, 8'd255);
		send_item(OP_DRAIN, 8'hA5, 8'h5A, 8'hFF);
		send_item(OP_PIXEL, 8'h55, 8'hAA, 8'h01);
		send_item(OP_PIXEL, 8'h80, 8'h7F, 8'hFE);
		// Shrink the width under the half-filled first row and cut the height,
		// then finish the frame at 3 x 4.
		settle_block();
		program_frame(1'b1, 16'd3, 1'b1, 16'd4);
		run_frame(0, 0, sent);

		// Zero width and height clamp to a single pixel; a stray pixel rides in
		// the flush.
		settle_block();
		program_frame(1'b1, '0, 1'b1, '0);
		send_item(OP_PIXEL, 8'd255, 8'd255, 8'd255);
		send_item(OP_PIXEL, 8'd0, 8'd0, 8'd0);
		send_item(OP_DRAIN, 8'd17, 8'd34, 8'd51);

		// Cut the height while the first output row is in progress.
		settle_block();
		program_frame(1'b1, 16'd4, 1'b1, 16'd5);
		send_item(OP_PIXEL, 8'd0, 8'd1, 8'd254);
		send_item(OP_PIXEL, 8'd255, 8'd254, 8'd1);
		send_item(OP_PIXEL, 8'd127, 8'd128, 8'd129);
		send_item(OP_PIXEL, 8'd3, 8'd4, 8'd5);
		send_item(OP_PIXEL, 8'd200, 8'd100, 8'd50);
		send_item(OP_PIXEL, 8'd9, 8'd8, 8'd7);
		settle_block();
		program_frame(1'b0, '0, 1'b1, 16'd2);
		run_frame(0, 0, sent);

		// Sender mostly busy, receiver often idle. An over-wide width clamps to
		// the maximum, so the first row runs long without wrapping; then the
		// width drops and the frame finishes.
		random_frames();
		settle_block();
		program_frame(1'b1, 16'd2047, 1'b1, 16'd2);
		repeat (WIDE_RUN) send_random(OP_PIXEL);
		settle_block();
		program_frame(1'b1, 16'd5, 1'b0, '0);
		run_frame(0, 0, sent);

		// Roles swapped; a frame with a few broken requests.
		set_idling(59, 29);
		random_frames();
		settle_block();
		program_frame(1'b1, 16'd12, 1'b1, 16'd3);
		run_frame(5, 30, sent);

		// No idling. First stall the receiver so the block backs up and raises
		// full, then more random frames.
		set_idling(0, 0);
		settle_block();
		program_frame(1'b1, 16'd8, 1'b1, 16'd8);
		rx_hold_req <= 1'b1;
		run_frame(0, 0, sent);
		random_frames();

		settle_block();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (blur_sb.mismatches == 0 && blur_sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
